// ----- hdl/tsc_pkg.sv -----
// Package with the shared constants, codes and state encoding of the 2-SAT checker.
package tsc_pkg;

  localparam int MAX_VARS_DEF    = 1024;
  localparam int MAX_CLAUSES_DEF = 8192;
  localparam int NUM_VARS_W      = 11;
  localparam int VAR_W           = 10;
  localparam int STATUS_W        = 2;
  localparam logic [NUM_VARS_W-1:0] NUM_VARS_RST = 11'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SAT   = 2'd0,
    ST_UNSAT = 2'd1,
    ST_OVF   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_ADD1,
    S_ADD2,
    S_RES,
    S_SSEL,
    S_SCHK,
    S_ENT,
    S_ENT2,
    S_LOOP,
    S_EDG1,
    S_EDG2,
    S_POPC,
    S_POPW,
    S_RET,
    S_RET2,
    S_CKA,
    S_CKB,
    S_CKC
  } eng_state_t;

endpackage

// ----- hdl/tsc_edge_mem.sv -----
// Edge store memory: target node and next-edge link, one write and one registered read port.
module tsc_edge_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/tsc_engine.sv -----
// Sequencer that stores clauses and runs the strongly connected component search.
module tsc_engine #(
  parameter int MAX_VARS    = tsc_pkg::MAX_VARS_DEF,
  parameter int MAX_CLAUSES = tsc_pkg::MAX_CLAUSES_DEF,
  parameter int VCW         = $clog2(MAX_VARS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [VCW-1:0]             nv,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [tsc_pkg::VAR_W-1:0]  var_a,
  input  logic                       side_a,
  input  logic [tsc_pkg::VAR_W-1:0]  var_b,
  input  logic                       side_b,
  output logic                       res_push,
  input  logic                       res_free,
  output tsc_pkg::status_t           res_status
);
  import tsc_pkg::*;

  localparam int N   = 2 * MAX_VARS;
  localparam int E   = 2 * MAX_CLAUSES;
  localparam int NB  = $clog2(N);
  localparam int EAW = $clog2(E);
  localparam int EPB = $clog2(E + 1);
  localparam int VB  = $clog2(N + 1);
  localparam int CCW = $clog2(MAX_CLAUSES + 1);
  localparam int EDW = NB + EPB;
  localparam int FW  = NB + EPB + 2 * VB;

  eng_state_t state_r, state_nxt;

  logic [NB-1:0]  u_r, u_nxt, w_r, w_nxt, fa_r, fa_nxt, fb_r, fb_nxt;
  logic [NB-1:0]  ta_r, ta_nxt, tb_r, tb_nxt, clr_r, clr_nxt;
  logic [EPB-1:0] e_r, e_nxt;
  logic [VB-1:0]  low_r, low_nxt, uvo_r, uvo_nxt, vc_r, vc_nxt, comp_r, comp_nxt;
  logic [VB-1:0]  nsp_r, nsp_nxt, csp_r, csp_nxt, a_r, a_nxt;
  logic [VCW-1:0] i_r, i_nxt;
  logic           s_r, s_nxt, top_r, top_nxt, clr_after_r, clr_after_nxt;
  logic [CCW-1:0] cnt_r, cnt_nxt;
  status_t        sticky_r, sticky_nxt, res_r, res_nxt;

  logic [EPB-1:0] hd_mem [N];
  logic [VB-1:0]  vo_mem [N];
  logic [VB-1:0]  ci_mem [N];
  logic [NB-1:0]  ns_mem [N];
  logic [FW-1:0]  cs_mem [N];

  logic           hd_we, vo_we, ci_we, ns_we, cs_we, ed_we;
  logic [NB-1:0]  hd_wa, hd_ra, vo_wa, vo_ra, ci_wa, ci_ra, ns_wa, ns_ra, cs_wa, cs_ra;
  logic [EPB-1:0] hd_wd, hd_q;
  logic [VB-1:0]  vo_wd, vo_q, ci_wd, ci_q;
  logic [NB-1:0]  ns_wd, ns_q;
  logic [FW-1:0]  cs_wd, cs_q;
  logic [EAW-1:0] ed_wa, ed_ra;
  logic [EDW-1:0] ed_wd, ed_q;

  logic [EAW-1:0] slot0, slot1;
  logic [NB-1:0]  start_node, v_node;
  logic [EPB-1:0] head_fwd;
  logic           range_bad;

  tsc_edge_mem #(.DEPTH(E), .AW(EAW), .DW(EDW)) u_edge (
    .clk     (clk),
    .wr_en   (ed_we),
    .wr_addr (ed_wa),
    .wr_data (ed_wd),
    .rd_addr (ed_ra),
    .rd_data (ed_q)
  );

  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    if (vo_we) vo_mem[vo_wa] <= vo_wd;
    if (ci_we) ci_mem[ci_wa] <= ci_wd;
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    if (cs_we) cs_mem[cs_wa] <= cs_wd;
    hd_q <= hd_mem[hd_ra];
    vo_q <= vo_mem[vo_ra];
    ci_q <= ci_mem[ci_ra];
    ns_q <= ns_mem[ns_ra];
    cs_q <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      sticky_r    <= ST_SAT;
      top_r       <= 1'b0;
      clr_after_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      sticky_r    <= sticky_nxt;
      top_r       <= top_nxt;
      clr_after_r <= clr_after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    w_r    <= w_nxt;
    fa_r   <= fa_nxt;
    fb_r   <= fb_nxt;
    ta_r   <= ta_nxt;
    tb_r   <= tb_nxt;
    e_r    <= e_nxt;
    low_r  <= low_nxt;
    uvo_r  <= uvo_nxt;
    vc_r   <= vc_nxt;
    comp_r <= comp_nxt;
    nsp_r  <= nsp_nxt;
    csp_r  <= csp_nxt;
    a_r    <= a_nxt;
    i_r    <= i_nxt;
    s_r    <= s_nxt;
    res_r  <= res_nxt;
  end

  assign slot0      = EAW'(32'(cnt_r) * 2);
  assign slot1      = EAW'(32'(cnt_r) * 2 + 1);
  assign start_node = NB'(32'(i_r) + (s_r ? 32'(MAX_VARS) : 32'd0));
  assign v_node     = ed_q[EDW-1:EPB];
  assign head_fwd   = (fb_r == fa_r) ? EPB'(32'(slot0) + 1) : hd_q;
  assign range_bad  = (32'(var_a) >= 32'(nv)) || (32'(var_b) >= 32'(nv));
  assign in_ready   = (state_r == S_IDLE);
  assign res_status = res_r;

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    clr_nxt       = clr_r;
    e_nxt         = e_r;
    low_nxt       = low_r;
    uvo_nxt       = uvo_r;
    vc_nxt        = vc_r;
    comp_nxt      = comp_r;
    nsp_nxt       = nsp_r;
    csp_nxt       = csp_r;
    a_nxt         = a_r;
    i_nxt         = i_r;
    s_nxt         = s_r;
    top_nxt       = top_r;
    clr_after_nxt = clr_after_r;
    cnt_nxt       = cnt_r;
    sticky_nxt    = sticky_r;
    res_nxt       = res_r;
    res_push      = 1'b0;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    vo_we = 1'b0; vo_wa = '0; vo_wd = '0; vo_ra = '0;
    ci_we = 1'b0; ci_wa = '0; ci_wd = '0; ci_ra = '0;
    ns_we = 1'b0; ns_wa = '0; ns_wd = '0; ns_ra = '0;
    cs_we = 1'b0; cs_wa = '0; cs_wd = '0; cs_ra = '0;
    ed_we = 1'b0; ed_wa = '0; ed_wd = '0; ed_ra = '0;

    unique case (state_r)
      S_CLR: begin
        hd_we = 1'b1; hd_wa = clr_r; hd_wd = '0;
        vo_we = 1'b1; vo_wa = clr_r; vo_wd = '0;
        ci_we = 1'b1; ci_wa = clr_r; ci_wd = '0;
        cnt_nxt    = '0;
        sticky_nxt = ST_SAT;
        if (32'(clr_r) == N - 1) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action) begin
            if (sticky_r != ST_SAT) begin
              res_nxt       = sticky_r;
              clr_after_nxt = 1'b1;
              state_nxt     = S_RES;
            end else begin
              i_nxt     = '0;
              s_nxt     = 1'b0;
              vc_nxt    = '0;
              comp_nxt  = '0;
              nsp_nxt   = '0;
              csp_nxt   = '0;
              top_nxt   = 1'b0;
              state_nxt = S_SSEL;
            end
          end else if (range_bad) begin
            res_nxt       = ST_RANGE;
            clr_after_nxt = 1'b0;
            if (sticky_r == ST_SAT) sticky_nxt = ST_RANGE;
            state_nxt = S_RES;
          end else if (32'(cnt_r) >= MAX_CLAUSES) begin
            res_nxt       = ST_OVF;
            clr_after_nxt = 1'b0;
            if (sticky_r == ST_SAT) sticky_nxt = ST_OVF;
            state_nxt = S_RES;
          end else begin
            fa_nxt    = NB'(32'(var_a) + (side_a ? 32'(MAX_VARS) : 32'd0));
            ta_nxt    = NB'(32'(var_b) + (side_b ? 32'd0 : 32'(MAX_VARS)));
            fb_nxt    = NB'(32'(var_b) + (side_b ? 32'(MAX_VARS) : 32'd0));
            tb_nxt    = NB'(32'(var_a) + (side_a ? 32'd0 : 32'(MAX_VARS)));
            hd_ra     = NB'(32'(var_a) + (side_a ? 32'(MAX_VARS) : 32'd0));
            state_nxt = S_ADD1;
          end
        end
      end
      S_ADD1: begin
        ed_we = 1'b1; ed_wa = slot0; ed_wd = {ta_r, hd_q};
        hd_we = 1'b1; hd_wa = fa_r; hd_wd = EPB'(32'(slot0) + 1);
        hd_ra = fb_r;
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        ed_we = 1'b1; ed_wa = slot1; ed_wd = {tb_r, head_fwd};
        hd_we = 1'b1; hd_wa = fb_r; hd_wd = EPB'(32'(slot1) + 1);
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_RES: begin
        if (res_free) begin
          res_push  = 1'b1;
          clr_nxt   = '0;
          state_nxt = clr_after_r ? S_CLR : S_IDLE;
        end
      end
      S_SSEL: begin
        if (i_r < nv) begin
          vo_ra     = start_node;
          w_nxt     = start_node;
          state_nxt = S_SCHK;
        end else if (!s_r) begin
          s_nxt = 1'b1;
          i_nxt = '0;
        end else begin
          i_nxt     = '0;
          state_nxt = S_CKA;
        end
      end
      S_SCHK: begin
        if (vo_q == '0) begin
          state_nxt = S_ENT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SSEL;
        end
      end
      S_ENT: begin
        vc_nxt = vc_r + 1'b1;
        vo_we = 1'b1; vo_wa = w_r; vo_wd = vc_r + 1'b1;
        ns_we = 1'b1; ns_wa = nsp_r[NB-1:0]; ns_wd = w_r;
        nsp_nxt = nsp_r + 1'b1;
        if (top_r) begin
          cs_we   = 1'b1;
          cs_wa   = csp_r[NB-1:0];
          cs_wd   = {u_r, e_r, low_r, uvo_r};
          csp_nxt = csp_r + 1'b1;
        end
        hd_ra     = w_r;
        u_nxt     = w_r;
        low_nxt   = vc_r + 1'b1;
        uvo_nxt   = vc_r + 1'b1;
        top_nxt   = 1'b1;
        state_nxt = S_ENT2;
      end
      S_ENT2: begin
        e_nxt     = hd_q;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (e_r != '0) begin
          ed_ra     = EAW'(e_r - 1'b1);
          state_nxt = S_EDG1;
        end else if (low_r == uvo_r) begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_POPC;
        end else begin
          state_nxt = S_RET;
        end
      end
      S_EDG1: begin
        e_nxt     = ed_q[EPB-1:0];
        vo_ra     = v_node;
        ci_ra     = v_node;
        w_nxt     = v_node;
        state_nxt = S_EDG2;
      end
      S_EDG2: begin
        if (vo_q == '0) begin
          state_nxt = S_ENT;
        end else begin
          if (ci_q == '0 && vo_q < low_r) low_nxt = vo_q;
          state_nxt = S_LOOP;
        end
      end
      S_POPC: begin
        ns_ra     = NB'(nsp_r - 1'b1);
        nsp_nxt   = nsp_r - 1'b1;
        state_nxt = S_POPW;
      end
      S_POPW: begin
        ci_we = 1'b1; ci_wa = ns_q; ci_wd = comp_r;
        state_nxt = (ns_q == u_r) ? S_RET : S_POPC;
      end
      S_RET: begin
        if (csp_r != '0) begin
          cs_ra     = NB'(csp_r - 1'b1);
          csp_nxt   = csp_r - 1'b1;
          state_nxt = S_RET2;
        end else begin
          top_nxt   = 1'b0;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SSEL;
        end
      end
      S_RET2: begin
        u_nxt     = cs_q[FW-1 -: NB];
        e_nxt     = cs_q[2*VB +: EPB];
        uvo_nxt   = cs_q[VB-1:0];
        low_nxt   = (low_r < cs_q[VB +: VB]) ? low_r : cs_q[VB +: VB];
        state_nxt = S_LOOP;
      end
      S_CKA: begin
        if (i_r < nv) begin
          ci_ra     = NB'(i_r);
          state_nxt = S_CKB;
        end else begin
          res_nxt       = ST_SAT;
          clr_after_nxt = 1'b1;
          state_nxt     = S_RES;
        end
      end
      S_CKB: begin
        a_nxt     = ci_q;
        ci_ra     = NB'(32'(i_r) + MAX_VARS);
        state_nxt = S_CKC;
      end
      S_CKC: begin
        if (a_r == ci_q) begin
          res_nxt       = ST_UNSAT;
          clr_after_nxt = 1'b1;
          state_nxt     = S_RES;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_CKA;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

// ----- hdl/two_sat_scc_checker_unit.sv -----
// Top level of the 2-SAT checker: configuration register, result register and engine.
// An add word gives a result only when it is dropped (range or overflow). A solve word
// walks every literal node below num_vars with an explicit call stack: it scans each
// literal as a start, enters each unvisited node and follows its stored edges, returns
// to the caller, closes finished nodes into a component and finally checks the two
// literals of each variable, reading the node, edge and stack memories through
// registered ports. After reset and after every solve the node memories are cleared
// in a pass over every node address during which no word is accepted. A finished
// result waits in an output register while the next word is taken.
module two_sat_scc_checker_unit #(
  parameter int MAX_VARS    = tsc_pkg::MAX_VARS_DEF,
  parameter int MAX_CLAUSES = tsc_pkg::MAX_CLAUSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tsc_pkg::NUM_VARS_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [tsc_pkg::VAR_W-1:0]     in_var_a,
  input  logic                          in_side_a,
  input  logic [tsc_pkg::VAR_W-1:0]     in_var_b,
  input  logic                          in_side_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsc_pkg::STATUS_W-1:0]  out_status
);
  import tsc_pkg::*;

  localparam int VCW = $clog2(MAX_VARS + 1);

  logic [NUM_VARS_W-1:0] num_vars_r;
  logic [VCW-1:0]        nv;
  logic                  out_valid_r;
  status_t               out_status_r, res_status;
  logic                  res_push, res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= NUM_VARS_RST;
    end else if (cfg_we) begin
      num_vars_r <= cfg_wdata;
    end
  end

  assign nv = (32'(num_vars_r) > MAX_VARS) ? VCW'(MAX_VARS) : VCW'(num_vars_r);

  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_status_r <= res_status;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  tsc_engine #(.MAX_VARS(MAX_VARS), .MAX_CLAUSES(MAX_CLAUSES), .VCW(VCW)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .nv         (nv),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (in_action),
    .var_a      (in_var_a),
    .side_a     (in_side_a),
    .var_b      (in_var_b),
    .side_b     (in_side_b),
    .res_push   (res_push),
    .res_free   (res_free),
    .res_status (res_status)
  );

endmodule

// ----- sim/two_sat_scc_checker_unit_chk.sv -----
// Checker that predicts the satisfiability verdicts of the 2-SAT checker and compares them.
module two_sat_scc_checker_unit_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [9:0]  in_var_a,
  input  logic        in_side_a,
  input  logic [9:0]  in_var_b,
  input  logic        in_side_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          verdicts_seen
);
  import tsc_pkg::*;

  localparam int NV = MAX_VARS_DEF;
  localparam int NODES = 2 * NV;
  localparam int EDGES = 2 * MAX_CLAUSES_DEF;

  logic [10:0] var_limit;
  int          arc_dst [EDGES];
  int          arc_nxt [EDGES];
  int          adj_head [NODES];
  int          clauses;
  status_t     first_err;
  status_t     verdict_q[$];

  int ord [NODES];
  int lowv [NODES];
  int comp [NODES];
  int nstk [NODES];
  int cnode [NODES];
  int carc [NODES];

  function automatic status_t solve_graph();
    int nv, nsp, csp, vcnt, ccnt, u, e, v, x, p, n;
    nv = (var_limit > NV) ? NV : var_limit;
    nsp = 0; csp = 0; vcnt = 0; ccnt = 0;
    for (int i = 0; i < NODES; i++) begin
      ord[i] = 0; lowv[i] = 0; comp[i] = 0;
    end
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < nv; i++) begin
        n = i + s * NV;
        if (ord[n] == 0) begin
          vcnt++; ord[n] = vcnt; lowv[n] = vcnt;
          nstk[nsp++] = n; cnode[csp] = n; carc[csp] = adj_head[n]; csp++;
          while (csp > 0) begin
            u = cnode[csp-1];
            e = carc[csp-1];
            if (e != 0) begin
              v = arc_dst[e-1];
              carc[csp-1] = arc_nxt[e-1];
              if (ord[v] == 0) begin
                vcnt++; ord[v] = vcnt; lowv[v] = vcnt;
                nstk[nsp++] = v; cnode[csp] = v; carc[csp] = adj_head[v]; csp++;
              end else if (comp[v] == 0 && ord[v] < lowv[u]) begin
                lowv[u] = ord[v];
              end
            end else begin
              csp--;
              if (lowv[u] == ord[u]) begin
                ccnt++;
                while (nsp > 0) begin
                  nsp--;
                  x = nstk[nsp];
                  comp[x] = ccnt;
                  if (x == u) break;
                end
              end
              if (csp > 0) begin
                p = cnode[csp-1];
                if (lowv[u] < lowv[p]) lowv[p] = lowv[u];
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < nv; i++) begin
      if (comp[i] == comp[i + NV]) return ST_UNSAT;
    end
    return ST_SAT;
  endfunction

  task automatic clear_instance();
    for (int i = 0; i < NODES; i++) adj_head[i] = 0;
    clauses = 0;
    first_err = ST_SAT;
  endtask

  task automatic take_word();
    int nv, slot;
    nv = (var_limit > NV) ? NV : var_limit;
    if (in_action) begin
      verdict_q.insert(verdict_q.size(), first_err != ST_SAT ? first_err : solve_graph());
      clear_instance();
    end else if (in_var_a >= nv || in_var_b >= nv) begin
      if (first_err == ST_SAT) first_err = ST_RANGE;
      verdict_q.insert(verdict_q.size(), ST_RANGE);
    end else if (clauses >= MAX_CLAUSES_DEF) begin
      if (first_err == ST_SAT) first_err = ST_OVF;
      verdict_q.insert(verdict_q.size(), ST_OVF);
    end else begin
      slot = 2 * clauses;
      arc_dst[slot] = in_var_b + (1 - in_side_b) * NV;
      arc_nxt[slot] = adj_head[in_var_a + in_side_a * NV];
      adj_head[in_var_a + in_side_a * NV] = slot + 1;
      arc_dst[slot+1] = in_var_a + (1 - in_side_a) * NV;
      arc_nxt[slot+1] = adj_head[in_var_b + in_side_b * NV];
      adj_head[in_var_b + in_side_b * NV] = slot + 2;
      clauses++;
    end
  endtask

  initial begin
    fail_count = 0;
    verdicts_seen = 0;
    var_limit = NUM_VARS_RST;
    clear_instance();
  end

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      var_limit = NUM_VARS_RST;
      clear_instance();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result word, status %0d", out_status);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Status mismatch: expected %0d, got %0d", want, out_status);
          end
        end
      end
      if (in_valid && in_ready) take_word();
      if (cfg_we) var_limit = cfg_wdata;
    end
  end
endmodule

// ----- sim/two_sat_scc_checker_unit_tb.sv -----
// Testbench top that drives words and configuration into the 2-SAT checker and gives the verdict.
module two_sat_scc_checker_unit_tb;
  import tsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [9:0]  in_var_a = '0;
  logic        in_side_a = 1'b0;
  logic [9:0]  in_var_b = '0;
  logic        in_side_b = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  int          fail_count, pending, verdicts_seen;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 1'b0;
  int          words_sent = 0;
  logic [10:0] nv_cur = 11'd1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  two_sat_scc_checker_unit DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_var_a(in_var_a), .in_side_a(in_side_a), .in_var_b(in_var_b),
    .in_side_b(in_side_b), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status)
  );

  two_sat_scc_checker_unit_chk u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_var_a(in_var_a), .in_side_a(in_side_a), .in_var_b(in_var_b),
    .in_side_b(in_side_b), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .fail_count(fail_count), .pending(pending),
    .verdicts_seen(verdicts_seen)
  );

  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(input int act, input int va, input int sa, input int vb,
                           input int sb);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act[0];
    in_var_a <= va[9:0];
    in_side_a <= sa[0];
    in_var_b <= vb[9:0];
    in_side_b <= sb[0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_vars(input logic [10:0] nv);
    drop_input();
    while (pending != 0) @(negedge clk);
    repeat (4200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= nv;
    nv_cur = nv;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_var(input int nv);
    if (nv == 0) return $urandom_range(1023);
    if ($urandom_range(19) == 0) return $urandom_range(1023);
    return $urandom_range(((nv > 1024) ? 1024 : nv) - 1);
  endfunction

  task automatic random_instance(input int nv, input int clauses);
    for (int i = 0; i < clauses; i++)
      send_word(0, pick_var(nv), $urandom_range(1), pick_var(nv), $urandom_range(1));
    send_word(1, $urandom_range(1023), $urandom_range(1), $urandom_range(1023),
              $urandom_range(1));
  endtask

  task automatic random_phase(input int words);
    int start, nv;
    start = words_sent;
    while (words_sent - start < words) begin
      nv = $urandom_range(1, 12);
      if (nv_cur != nv) set_vars(11'(nv));
      random_instance(nv, $urandom_range(0, 3 * nv));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_word(0, 0, 0, 0, 1);
    send_word(0, 0, 1, 0, 0);
    send_word(1, 0, 0, 0, 0);
    send_word(0, 1, 0, 0, 0);
    send_word(1, 0, 0, 0, 0);
    set_vars(11'd0);
    send_word(0, 0, 0, 0, 0);
    send_word(1, 0, 0, 0, 0);
    set_vars(11'd2047);
    send_word(0, 1023, 1, 1023, 1);
    send_word(0, 0, 0, 1023, 0);
    send_word(0, 1023, 0, 0, 1);
    send_word(1, 1023, 1, 1023, 1);
    set_vars(11'd1024);
    send_word(0, 512, 0, 513, 1);
    send_word(0, 512, 1, 513, 0);
    send_word(0, 512, 0, 513, 0);
    send_word(0, 512, 1, 513, 1);
    send_word(1, 0, 0, 0, 0);
    set_vars(11'd3);
    send_word(0, 0, 0, 2, 0);
    send_word(0, 0, 1, 1, 1);
    set_vars(11'd1);
    send_word(1, 0, 0, 0, 0);
    set_vars(11'd2);
    for (int i = 0; i < 16; i++) begin
      send_word(0, i & 1, (i >> 1) & 1, 1, 1);
    end
    send_word(0, 0, 0, 1, 0);
    send_word(1, 0, 0, 0, 0);
    set_vars(11'd6);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_word(0, 7, 0, 7, 0);
        for (int i = 0; i < 4; i++) send_word(0, 9, 1, 9, 1);
      end
    join
    send_word(1, 0, 0, 0, 0);
    send_idle = 20; recv_idle = 86;
    random_phase(430);
    send_idle = 86; recv_idle = 20;
    random_phase(430);
    send_idle = 0; recv_idle = 0;
    random_phase(430);
    drop_input();
    while (pending != 0) @(negedge clk);
    repeat (4200) @(negedge clk);
    $display("Covered %0d input words and %0d result words over several num_vars settings,",
             words_sent, verdicts_seen);
    $display("including range errors, sticky error codes and long output stalls.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
